// File: hdl/alu_8bit_with_booth_multiply_top_defines.svh
// Assertion macros used by the checker file of the ALU block.
`ifndef ALU_8BIT_WITH_BOOTH_MULTIPLY_TOP_DEFINES_SVH
`define ALU_8BIT_WITH_BOOTH_MULTIPLY_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ABM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ALU checker: property failed");

// The consequent must hold in the cycle after the antecedent.
`define ABM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ALU checker: property failed");

`endif

// File: hdl/abm_pkg.sv
package abm_pkg;

    // Operand width and derived widths.
    localparam int DW     = 8;
    localparam int RES_W  = 2 * DW;
    localparam int HALF_W = DW / 2;
    localparam int OP_W   = 4;

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_ADD = 4'd1,
        OP_SUB = 4'd2,
        OP_MUL = 4'd3,
        OP_AND = 4'd4,
        OP_OR  = 4'd5,
        OP_NOT = 4'd6,
        OP_XOR = 4'd7,
        OP_SHR = 4'd8,
        OP_SHL = 4'd9
    } t_opcode;

    // Result of the non-multiply datapath.
    typedef struct packed {
        logic [DW-1:0] value;
        logic          carry;
        logic          overflow;
        logic          is_mul;
        logic          bad;
    } t_alu_res;

endpackage

// File: hdl/abm_booth4.sv
module abm_booth4 import abm_pkg::*; (
    input  logic [RES_W-1:0]  i_acc,
    input  logic [RES_W-1:0]  i_mcand,
    input  logic [HALF_W:0]   i_bits,
    output logic [RES_W-1:0]  o_acc
);

    // Half of the radix-2 Booth recoding: each bit pair adds, subtracts or skips
    // the multiplicand shifted to that bit position.
    always_comb begin
        logic [RES_W-1:0] acc;
        acc = i_acc;
        for (int j = 0; j < HALF_W; j++) begin
            unique case ({i_bits[j+1], i_bits[j]})
                2'b10:   acc = acc - (i_mcand << j);
                2'b01:   acc = acc + (i_mcand << j);
                default: acc = acc;
            endcase
        end
        o_acc = acc;
    end

endmodule

// File: hdl/abm_alu.sv
module abm_alu import abm_pkg::*; (
    input  logic [DW-1:0]   i_a,
    input  logic [DW-1:0]   i_b,
    input  logic [OP_W-1:0] i_op,
    output t_alu_res        o_res
);

    // Adder and logic unit for every opcode except the multiply.
    always_comb begin
        logic [DW:0]   sum;
        logic [DW-1:0] neg_b;
        sum   = '0;
        neg_b = (~i_b) + {{(DW-1){1'b0}}, 1'b1};
        o_res = '0;
        unique case (t_opcode'(i_op))
            OP_ADD: begin
                sum            = {1'b0, i_a} + {1'b0, i_b};
                o_res.value    = sum[DW-1:0];
                o_res.carry    = sum[DW];
                o_res.overflow = ~(i_a[DW-1] ^ i_b[DW-1]) & (i_a[DW-1] ^ sum[DW-1]);
            end
            OP_SUB: begin
                sum            = {1'b0, i_a} + {1'b0, neg_b};
                o_res.value    = sum[DW-1:0];
                o_res.carry    = sum[DW];
                o_res.overflow = (i_a[DW-1] ^ i_b[DW-1]) & (i_a[DW-1] ^ sum[DW-1]);
            end
            OP_MUL: o_res.is_mul = 1'b1;
            OP_AND: o_res.value  = i_a & i_b;
            OP_OR:  o_res.value  = i_a | i_b;
            OP_NOT: o_res.value  = ~i_a;
            OP_XOR: o_res.value  = i_a ^ i_b;
            OP_SHR: begin
                o_res.value = {1'b0, i_a[DW-1:1]};
                o_res.carry = i_a[0];
            end
            OP_SHL: begin
                o_res.value = {i_a[DW-2:0], 1'b0};
                o_res.carry = i_a[DW-1];
            end
            default: o_res.bad = 1'b1;
        endcase
    end

endmodule

// File: hdl/alu_8bit_with_booth_multiply_top.sv
// ALU with signed radix-2 Booth multiply, three register stages.
// For every opcode, the result strobes after the s1, s2 and output registers.
// Throughput: one operation per cycle; busy stays low, as the three-stage pipeline
// and its two Booth halves never stall and the receiver always takes the result.
// Reset (synchronous, active low) clears the stage valid bits; no result strobes
// until an operation started after reset has passed all three stages.
module alu_8bit_with_booth_multiply_top import abm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [DW-1:0]     i_operand_a,
    input  logic [DW-1:0]     i_operand_b,
    input  logic [OP_W-1:0]   i_operation,
    output logic              o_result_valid,
    output logic [RES_W-1:0]  o_result_value,
    output logic              o_carry_flag,
    output logic              o_zero_flag,
    output logic              o_overflow_flag,
    output logic              o_sign_flag,
    output logic              o_unrecognized
);

    // Stage one: operand capture.
    logic              r_s1_valid;
    logic [DW-1:0]     r_s1_a;
    logic [DW-1:0]     r_s1_b;
    logic [OP_W-1:0]   r_s1_op;

    // Stage two: adder/logic results and the first Booth half.
    logic              r_s2_valid;
    logic [DW-1:0]     r_s2_a;
    logic [DW-1:0]     r_s2_b;
    t_alu_res          r_s2_alu;
    logic [RES_W-1:0]  r_s2_acc;

    // Output stage.
    logic              r_out_valid;
    logic [RES_W-1:0]  r_out_value;
    logic              r_out_carry;
    logic              r_out_zero;
    logic              r_out_overflow;
    logic              r_out_sign;
    logic              r_out_bad;

    logic [RES_W-1:0]  n_out_value;
    logic              n_out_zero;
    logic              n_out_sign;

    t_alu_res          s1_alu;
    logic [RES_W-1:0]  s1_mcand;
    logic [RES_W-1:0]  s1_acc;
    logic [RES_W-1:0]  s2_mcand;
    logic [RES_W-1:0]  s2_acc;

    assign busy = 1'b0;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= start && !busy;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    // Capture the operands of each transfer.
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_s1_a  <= i_operand_a;
            r_s1_b  <= i_operand_b;
            r_s1_op <= i_operation;
        end
    end

    abm_alu u_alu (
        .i_a   (r_s1_a),
        .i_b   (r_s1_b),
        .i_op  (r_s1_op),
        .o_res (s1_alu)
    );

    // Sign-extended multiplicand; the low multiplier bits are recoded first.
    assign s1_mcand = {{(RES_W-DW){r_s1_a[DW-1]}}, r_s1_a};

    abm_booth4 u_booth_lo (
        .i_acc   ({RES_W{1'b0}}),
        .i_mcand (s1_mcand),
        .i_bits  ({r_s1_b[HALF_W-1:0], 1'b0}),
        .o_acc   (s1_acc)
    );

    always_ff @(posedge i_clk) begin
        r_s2_a   <= r_s1_a;
        r_s2_b   <= r_s1_b;
        r_s2_alu <= s1_alu;
        r_s2_acc <= s1_acc;
    end

    // The upper multiplier bits finish the product.
    assign s2_mcand = {{(RES_W-DW){r_s2_a[DW-1]}}, r_s2_a} << HALF_W;

    abm_booth4 u_booth_hi (
        .i_acc   (r_s2_acc),
        .i_mcand (s2_mcand),
        .i_bits  (r_s2_b[DW-1:HALF_W-1]),
        .o_acc   (s2_acc)
    );

    // Result select and flags; an unknown opcode leaves everything cleared.
    always_comb begin
        n_out_value = r_s2_alu.is_mul ? s2_acc : {{(RES_W-DW){1'b0}}, r_s2_alu.value};
        n_out_zero  = !r_s2_alu.bad && (n_out_value == '0);
        n_out_sign  = r_s2_alu.is_mul ? n_out_value[RES_W-1] : n_out_value[DW-1];
    end

    always_ff @(posedge i_clk) begin
        r_out_value    <= n_out_value;
        r_out_carry    <= r_s2_alu.carry;
        r_out_zero     <= n_out_zero;
        r_out_overflow <= r_s2_alu.overflow;
        r_out_sign     <= n_out_sign;
        r_out_bad      <= r_s2_alu.bad;
    end

    assign o_result_valid  = r_out_valid;
    assign o_result_value  = r_out_value;
    assign o_carry_flag    = r_out_carry;
    assign o_zero_flag     = r_out_zero;
    assign o_overflow_flag = r_out_overflow;
    assign o_sign_flag     = r_out_sign;
    assign o_unrecognized  = r_out_bad;

endmodule

// File: hdl/abm_checker.sv
`include "alu_8bit_with_booth_multiply_top_defines.svh"

module abm_checker import abm_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic [DW-1:0]     i_operand_a,
    input logic [DW-1:0]     i_operand_b,
    input logic [OP_W-1:0]   i_operation,
    input logic              o_result_valid,
    input logic [RES_W-1:0]  o_result_value,
    input logic              o_carry_flag,
    input logic              o_zero_flag,
    input logic              o_overflow_flag,
    input logic              o_sign_flag,
    input logic              o_unrecognized
);

    // Every transfer yields exactly one result, and every result comes from a transfer.
    `ABM_ASSERT_NOW(a_fixed_latency, start && !busy, ##3 o_result_valid)
    `ABM_ASSERT_NOW(a_no_phantom, o_result_valid, $past(start && !busy, 3))

    // An unknown opcode reports a cleared result and cleared flags.
    `ABM_ASSERT_NOW(a_bad_clears, o_result_valid && o_unrecognized,
        o_result_value == '0 && !o_carry_flag && !o_zero_flag &&
        !o_overflow_flag && !o_sign_flag)

    // The zero flag agrees with the reported result for known opcodes.
    `ABM_ASSERT_NOW(a_zero_match, o_result_valid && !o_unrecognized,
        o_zero_flag == (o_result_value == '0))

    // The pipeline never holds off the sender.
    `ABM_ASSERT_NEXT(a_never_busy, 1'b1, !busy)

endmodule

bind alu_8bit_with_booth_multiply_top abm_checker u_abm_checker (.*);
